// ----- design/mm_pkg.sv -----
// ----------------------------------------------------------------------------
// mm_pkg - shared types and constants for the matrix multiplier
// Field structs, opcodes, register indexes, sequencer states and sizing.
// ----------------------------------------------------------------------------
package mm_pkg;

	localparam int MAX_DIM = 8;
	localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int ADDR_W  = 2 * IDX_W;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 2 * ELEM_W;
	localparam int SUM_W   = 32;
	// exact sum of MAX_DIM products plus a sign bit
	localparam int ACC_W   = PROD_W + $clog2(MAX_DIM + 1) + 1;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int CFG_W   = 4;

	// pipeline depth behind the last A element of a row
	localparam int DRAIN_LAST = MAX_DIM + 1;
	localparam int CNT_W      = $clog2(DRAIN_LAST + 1);

	localparam logic [1:0] OP_LOAD_A  = 2'd0;
	localparam logic [1:0] OP_LOAD_B  = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_DIM = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;

	typedef struct packed {
		logic [1:0]               opcode;
		logic [2:0]               row;
		logic [2:0]               col;
		logic signed [ELEM_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]              out_row;
		logic [2:0]              out_col;
		logic signed [SUM_W-1:0] product_sum;
		logic                    last;
	} rsp_t;

	// one A element traveling down the cell chain
	typedef struct packed {
		logic                     valid;
		logic                     first;
		logic [IDX_W-1:0]         k;
		logic signed [ELEM_W-1:0] a;
	} flit_t;

	// write of one B element into a cell's column
	typedef struct packed {
		logic                     we;
		logic [IDX_W-1:0]         addr;
		logic signed [ELEM_W-1:0] data;
	} bwr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
		logic [DIM_W-1:0] d;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if (int'(r) > MAX_DIM) begin
			d = DIM_W'(MAX_DIM);
		end else begin
			d = DIM_W'(r);
		end
		return d;
	endfunction

endpackage

// ----- design/mm_ram.sv -----
// ----------------------------------------------------------------------------
// mm_ram - generic single write port, single read port RAM
// Registered read data; contents are undefined until written.
// ----------------------------------------------------------------------------
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/mm_cell.sv -----
// ----------------------------------------------------------------------------
// mm_cell - one multiply-accumulate cell of the chain
// Holds one column of B, multiplies each passing A element by its entry,
// accumulates the dot product and hands the element to the next cell.
// ----------------------------------------------------------------------------
module mm_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mm_pkg::flit_t                     flit_in,
	output mm_pkg::flit_t                     flit_out,
	input  mm_pkg::bwr_t                      bwr,
	output logic signed [mm_pkg::SUM_W-1:0]   sum
);

	import mm_pkg::*;

	logic signed [ELEM_W-1:0] bcol_q [MAX_DIM];
	logic signed [ELEM_W-1:0] b_sel;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic                     first_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     vld_q;
	flit_t                    flit_q;

	assign b_sel = bcol_q[flit_in.k];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_q  <= flit_in.valid;
			vld_s1 <= flit_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bwr.we) begin
			bcol_q[bwr.addr] <= bwr.data;
		end
		flit_q   <= flit_in;
		prod_s1  <= flit_in.a * b_sel;
		first_s1 <= flit_in.first;
		// restart the sum on the first element of a row
		if (vld_s1) begin
			acc_q <= (first_s1 ? '0 : acc_q)
				+ {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
		end
	end

	always_comb begin
		flit_out       = flit_q;
		flit_out.valid = vld_q;
	end

	// clamp to the signed 32-bit range
	always_comb begin
		if (acc_q[ACC_W-1:SUM_W-1] == '0 || acc_q[ACC_W-1:SUM_W-1] == '1) begin
			sum = acc_q[SUM_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			sum = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sum = {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

endmodule

// ----- design/matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply - fixed-point matrix multiplier on a chain of MAC cells
// Load items fill the A and B stores; a compute item emits C = A * B in
// row-major order with last set on the final element.
// ----------------------------------------------------------------------------
// Loads: one transfer per cycle while the sequencer is idle, no result.
// Compute: for each row of C the one read port of the A store feeds n
//   (inner_dim) elements into the chain, the row drains through the chain
//   depth, then its p (cols_b) sums are sent, which output stalls can hold.
//   No new request is taken meanwhile.
// Reset: dimension registers return to 8; element stores are undefined until
//   written and get no clearing pass.
// ----------------------------------------------------------------------------
module matrix_multiply (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  mm_pkg::req_t                  req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output mm_pkg::rsp_t                  rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mm_pkg::PADDR_W-1:0]    paddr,
	input  logic [mm_pkg::PDATA_W-1:0]    pwdata,
	output logic [mm_pkg::PDATA_W-1:0]    prdata,
	output logic                          pready
);

	import mm_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] inner_q;
	logic [CFG_W-1:0] cols_q;
	logic [DIM_W-1:0] m_eff;
	logic [DIM_W-1:0] n_eff;
	logic [DIM_W-1:0] p_eff;
	logic             cfg_wr;

	// sequencer
	state_t           state_q;
	state_t           state_nxt;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic [CNT_W-1:0] drain_q;
	logic             req_fire;
	logic             start;
	logic             feed_en;
	logic             last_k;
	logic             drain_done;
	logic             emit_load;
	logic             last_j;
	logic             last_i;

	// A store and chain feed
	logic               a_we;
	logic [ADDR_W-1:0]  a_waddr;
	logic [ADDR_W-1:0]  a_raddr;
	logic [ELEM_W-1:0]  a_rdata;
	logic               feed_vld_s1;
	logic               feed_first_s1;
	logic [IDX_W-1:0]   feed_k_s1;
	logic               in_range;
	flit_t              flit0;
	flit_t              chain [MAX_DIM];
	bwr_t               bwr [MAX_DIM];
	logic signed [SUM_W-1:0] sums [MAX_DIM];

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	// ------------------------------------------------------------------
	// Configuration port: writes complete in the access phase, no waits.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= CFG_W'(8);
			inner_q <= CFG_W'(8);
			cols_q  <= CFG_W'(8);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ROWS_A:    rows_q  <= pwdata[CFG_W-1:0];
				REG_INNER_DIM: inner_q <= pwdata[CFG_W-1:0];
				REG_COLS_B:    cols_q  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROWS_A:    prdata = {{(PDATA_W-CFG_W){1'b0}}, rows_q};
			REG_INNER_DIM: prdata = {{(PDATA_W-CFG_W){1'b0}}, inner_q};
			REG_COLS_B:    prdata = {{(PDATA_W-CFG_W){1'b0}}, cols_q};
			default:       prdata = '0;
		endcase
	end

	// zero means one, anything above the array size clamps to it
	assign m_eff = eff_dim(rows_q);
	assign n_eff = eff_dim(inner_q);
	assign p_eff = eff_dim(cols_q);

	// ------------------------------------------------------------------
	// Request side: loads go straight into the stores, compute starts
	// the sequencer. Out-of-range loads and the spare opcode drop.
	// ------------------------------------------------------------------
	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign in_range  = (int'(req.row) < MAX_DIM) && (int'(req.col) < MAX_DIM);
	assign start     = req_fire && (req.opcode == OP_COMPUTE);

	assign a_we    = req_fire && (req.opcode == OP_LOAD_A) && in_range;
	assign a_waddr = {IDX_W'(req.row), IDX_W'(req.col)};
	assign a_raddr = {i_q, k_q};

	mm_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(DEPTH)
	) u_a_store (
		.clk  (clk),
		.we   (a_we),
		.waddr(a_waddr),
		.wdata(req.value),
		.re   (feed_en),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	// B lives in the cells: cell g keeps column g
	for (genvar g = 0; g < MAX_DIM; g++) begin : g_bwr
		assign bwr[g].we   = req_fire && (req.opcode == OP_LOAD_B) && in_range
			&& (IDX_W'(req.col) == IDX_W'(g));
		assign bwr[g].addr = IDX_W'(req.row);
		assign bwr[g].data = req.value;
	end

	// ------------------------------------------------------------------
	// Sequencer: per row, feed A[i][0..n-1] into the chain, wait for the
	// chain to drain, then transfer the p sums of that row in order.
	// ------------------------------------------------------------------
	assign last_k     = (DIM_W'(k_q) == n_eff - DIM_W'(1));
	assign last_j     = (DIM_W'(j_q) == p_eff - DIM_W'(1));
	assign last_i     = (DIM_W'(i_q) == m_eff - DIM_W'(1));
	assign drain_done = (drain_q == CNT_W'(DRAIN_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		feed_en   = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_FEED;
				end
			end
			ST_FEED: begin
				feed_en = 1'b1;
				if (last_k) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_done) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				emit_load = !rsp_valid_q || rsp_ready;
				if (emit_load && last_j) begin
					state_nxt = last_i ? ST_IDLE : ST_FEED;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			drain_q <= '0;
		end else begin
			if (start) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end
			if (feed_en) begin
				k_q     <= last_k ? '0 : k_q + IDX_W'(1);
				drain_q <= '0;
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + CNT_W'(1);
			end
			if (emit_load) begin
				j_q <= last_j ? '0 : j_q + IDX_W'(1);
				if (last_j) begin
					i_q <= last_i ? '0 : i_q + IDX_W'(1);
				end
			end
		end
	end

	// align the element's tag with the registered store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_vld_s1 <= 1'b0;
		end else begin
			feed_vld_s1 <= feed_en;
		end
	end

	always_ff @(posedge clk) begin
		feed_first_s1 <= (k_q == '0);
		feed_k_s1     <= k_q;
	end

	assign flit0.valid = feed_vld_s1;
	assign flit0.first = feed_first_s1;
	assign flit0.k     = feed_k_s1;
	assign flit0.a     = a_rdata;

	// ------------------------------------------------------------------
	// Cell chain: each element advances one cell per cycle.
	// ------------------------------------------------------------------
	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		mm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.flit_in ((g == 0) ? flit0 : chain[(g == 0) ? 0 : g - 1]),
			.flit_out(chain[g]),
			.bwr     (bwr[g]),
			.sum     (sums[g])
		);
	end

	// ------------------------------------------------------------------
	// Output register: hold the result until its transfer completes.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			rsp_q.out_row     <= 3'(i_q);
			rsp_q.out_col     <= 3'(j_q);
			rsp_q.product_sum <= sums[j_q];
			rsp_q.last        <= last_i && last_j;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_chain_empty_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !chain[MAX_DIM-1].valid)
		else $error("chain still busy while emitting a row");

	a_feed_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FEED |-> DIM_W'(k_q) < n_eff && DIM_W'(i_q) < m_eff)
		else $error("feed index beyond the matrix");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> DIM_W'(j_q) < p_eff && DIM_W'(i_q) < m_eff)
		else $error("emit index beyond the matrix");

endmodule
